// ===== hw/rtl/iha_pkg.sv =====
// Package for the id handle allocator: payload structs, operation and
// status codes, sequencer states and the memory request struct.
// No dependencies.
package iha_pkg;

  localparam int ID_W         = 16;
  localparam int WORD_W       = 32;
  localparam int CAPACITY_DEF = 1024;

  // Operation codes carried in the mode field
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ID_W-1:0]   start_id;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   id_out;
    logic [WORD_W-1:0] value_out;
  } out_item_t;

  // One access to the table per cycle: a read or a write at addr
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ID_W-1:0]   addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_ARD,
    ST_ACHK,
    ST_FCHK,
    ST_RESP
  } state_t;

endpackage

// ===== hw/rtl/iha_table.sv =====
// Entry word table of the id handle allocator: single-port memory with a
// registered read and a clearing pass after reset.
// Depends on iha_pkg.
module iha_table #(
  parameter int CAPACITY = iha_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  iha_pkg::mem_req_t        mem_req,
  output logic [iha_pkg::WORD_W-1:0] mem_rdata,
  output logic                     clr_busy
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [AW:0] CAP_C = (AW+1)'(CAPACITY);

  logic [iha_pkg::WORD_W-1:0] mem [CAPACITY];
  logic [AW:0]                clr_r;
  logic [AW:0]                clr_nxt;
  logic [iha_pkg::WORD_W-1:0] rdata_r;

  assign clr_busy  = (clr_r != CAP_C);
  assign clr_nxt   = clr_busy ? (clr_r + 1'b1) : clr_r;
  assign mem_rdata = rdata_r;

  // Clear counter: walks every entry once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  // Write port, the clearing pass has priority
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_r[AW-1:0]] <= '0;
    end else if (mem_req.wr_en) begin
      mem[mem_req.addr[AW-1:0]] <= mem_req.wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rdata_r <= mem[mem_req.addr[AW-1:0]];
    end
  end

endmodule

// ===== hw/rtl/iha_ctrl.sv =====
// Sequencer of the id handle allocator: takes an item, scans or accesses
// the table one entry at a time and holds the result in an output register.
// Depends on iha_pkg.
module iha_ctrl #(
  parameter int CAPACITY = iha_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  iha_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output iha_pkg::out_item_t         out_item,
  output iha_pkg::mem_req_t          mem_req,
  input  logic [iha_pkg::WORD_W-1:0] mem_rdata,
  input  logic                       clr_busy
);

  localparam logic [iha_pkg::ID_W:0] CAP_L = (iha_pkg::ID_W+1)'(CAPACITY);

  iha_pkg::state_t           state_r, state_nxt;
  iha_pkg::in_item_t         op_r, op_nxt;
  iha_pkg::out_item_t        res_r, res_nxt;
  iha_pkg::out_item_t        out_item_r, out_item_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [iha_pkg::ID_W:0]    scan_r, scan_nxt;
  logic [iha_pkg::ID_W:0]    scan_inc;
  logic                      start_ok;
  logic                      id_ok;
  logic                      rd_zero;
  logic                      out_free;

  assign start_ok = ({1'b0, op_r.start_id} < CAP_L);
  assign id_ok    = ({1'b0, op_r.id} < CAP_L);
  assign scan_inc = scan_r + 1'b1;
  assign rd_zero  = (mem_rdata == '0);
  assign out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iha_pkg::ST_CLEAR: begin
        if (!clr_busy) state_nxt = iha_pkg::ST_IDLE;
      end
      iha_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = iha_pkg::ST_DISPATCH;
      end
      iha_pkg::ST_DISPATCH: begin
        case (op_r.mode)
          iha_pkg::OP_ALLOC: state_nxt = start_ok ? iha_pkg::ST_ARD : iha_pkg::ST_RESP;
          iha_pkg::OP_FIND:  state_nxt = id_ok ? iha_pkg::ST_FCHK : iha_pkg::ST_RESP;
          default:           state_nxt = iha_pkg::ST_RESP;
        endcase
      end
      iha_pkg::ST_ARD: begin
        state_nxt = iha_pkg::ST_ACHK;
      end
      iha_pkg::ST_ACHK: begin
        if (rd_zero || (scan_inc == CAP_L)) state_nxt = iha_pkg::ST_RESP;
        else state_nxt = iha_pkg::ST_ARD;
      end
      iha_pkg::ST_FCHK: begin
        state_nxt = iha_pkg::ST_RESP;
      end
      iha_pkg::ST_RESP: begin
        if (out_free) state_nxt = iha_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = iha_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs, table requests and datapath updates
  always_comb begin
    in_ready      = 1'b0;
    mem_req       = '0;
    op_nxt        = op_r;
    res_nxt       = res_r;
    scan_nxt      = scan_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      iha_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op_nxt = in_item;
      end
      iha_pkg::ST_DISPATCH: begin
        res_nxt = '{status: iha_pkg::STAT_OK, id_out: '0, value_out: '0};
        case (op_r.mode)
          iha_pkg::OP_ALLOC: begin
            scan_nxt = {1'b0, op_r.start_id};
            if (!start_ok) res_nxt.status = iha_pkg::STAT_FULL;
          end
          iha_pkg::OP_FIND: begin
            mem_req.rd_en = id_ok;
            mem_req.addr  = op_r.id;
            if (!id_ok) res_nxt.status = iha_pkg::STAT_RANGE;
          end
          iha_pkg::OP_REMOVE: begin
            mem_req.wr_en = id_ok;
            mem_req.addr  = op_r.id;
            if (!id_ok) res_nxt.status = iha_pkg::STAT_RANGE;
          end
          default: begin
          end
        endcase
      end
      iha_pkg::ST_ARD: begin
        mem_req.rd_en = 1'b1;
        mem_req.addr  = scan_r[iha_pkg::ID_W-1:0];
      end
      iha_pkg::ST_ACHK: begin
        // Free slot found: claim it, else step to the next id
        if (rd_zero) begin
          mem_req.wr_en  = 1'b1;
          mem_req.addr   = scan_r[iha_pkg::ID_W-1:0];
          mem_req.wdata  = op_r.value;
          res_nxt.id_out = scan_r[iha_pkg::ID_W-1:0];
        end else begin
          scan_nxt = scan_inc;
          if (scan_inc == CAP_L) res_nxt.status = iha_pkg::STAT_FULL;
        end
      end
      iha_pkg::ST_FCHK: begin
        res_nxt.value_out = mem_rdata;
      end
      iha_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iha_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    res_r      <= res_nxt;
    scan_r     <= scan_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== hw/rtl/id_handle_allocator_top.sv =====
// Top level of the id handle allocator: sequencer plus entry word table.
// Depends on iha_pkg, iha_ctrl and iha_table.
//
// Usage:
//   Input channel in_valid/in_ready/in_item carries one operation: allocate
//   (first free slot at or above start_id gets value), find (word at id) or
//   remove (clear word at id). Each item gives exactly one result on
//   out_valid/out_ready/out_item with a status, the allocated id and the
//   found word.
//   One item is in work at a time; in_ready is high only while idle.
//   Allocate examines slots upward from start_id, at most CAPACITY of them.
//   The single table port is the limit: each examined slot costs a table
//   read and a check step.
//   The next item is taken in the idle state that follows the loading of
//   the result.
//   After reset the table is cleared one entry per cycle, and in_ready
//   stays low until that pass ends.
//   The result sits in an output register; while the receiver stalls the
//   block still accepts the next item and holds its result until the
//   output register is free.
module id_handle_allocator_top #(
  parameter int CAPACITY = iha_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  iha_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output iha_pkg::out_item_t out_item
);

  iha_pkg::mem_req_t          mem_req;
  logic [iha_pkg::WORD_W-1:0] mem_rdata;
  logic                       clr_busy;

  iha_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .clr_busy  (clr_busy)
  );

  iha_table #(
    .CAPACITY (CAPACITY)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .clr_busy  (clr_busy)
  );

endmodule

// ===== test/iha_checker.sv =====
// Checker for the id handle allocator: watches both channels, keeps its own
// slot table, predicts each result and compares it with what the block returns.
// Depends on iha_pkg.
module iha_checker #(
  parameter int CAPACITY = iha_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  iha_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  iha_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import iha_pkg::*;

  // Shadow copy of the entry words; zero marks a free slot
  logic [WORD_W-1:0] slot_words [CAPACITY];
  // Results still owed by the block, oldest first
  out_item_t         owed_results [$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  // Apply one operation to the shadow table and return its result
  function automatic out_item_t apply_op(input in_item_t op);
    out_item_t res;
    int        slot;
    logic      found;
    res   = '0;
    found = 1'b0;
    case (op.mode)
      OP_ALLOC: begin
        // first free slot at or above start_id
        slot = int'(op.start_id);
        while (slot < CAPACITY && !found) begin
          if (slot_words[slot] == '0) begin
            slot_words[slot] = op.value;
            res.id_out       = ID_W'(slot);
            found            = 1'b1;
          end
          slot++;
        end
        res.status = found ? STAT_OK : STAT_FULL;
      end
      OP_FIND: begin
        if (int'(op.id) < CAPACITY) begin
          res.value_out = slot_words[op.id];
        end else begin
          res.status = STAT_RANGE;
        end
      end
      OP_REMOVE: begin
        if (int'(op.id) < CAPACITY) begin
          slot_words[op.id] = '0;
        end else begin
          res.status = STAT_RANGE;
        end
      end
      default: ;  // unused mode: all-zero result, table untouched
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Result side first, then the new item; a result never leaves in the
  // cycle its item is taken
  always @(posedge clk) begin : watch_edge
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) slot_words[i] = '0;
      owed_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with nothing owed", WORD_W'(out_item), '0);
        end else begin
          want = owed_results.pop_front();
          if (out_item.status != want.status)
            report_mismatch("status", WORD_W'(out_item.status), WORD_W'(want.status));
          if (out_item.id_out != want.id_out)
            report_mismatch("id_out", WORD_W'(out_item.id_out), WORD_W'(want.id_out));
          if (out_item.value_out != want.value_out)
            report_mismatch("value_out", out_item.value_out, want.value_out);
        end
      end
      if (in_valid && in_ready) owed_results.push_back(apply_op(in_item));
    end
    pending <= owed_results.size();
  end

endmodule

// ===== test/id_handle_allocator_top_test.sv =====
// Testbench top for the id handle allocator: clock, reset, directed and
// random operations, receiver stalls, watchdog and the verdict.
// Depends on iha_pkg, iha_checker and id_handle_allocator_top.
module id_handle_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import iha_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1680;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_GAP      = 12;
  // Longest quiet stretch: clearing pass, full-table scan, long hold, gaps
  localparam int WATCHDOG_LIMIT = 4 * (2 * CAPACITY + HOLD_CYCLES + MAX_GAP + 16)
                                  + CAPACITY + 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  logic      hold_req  = 1'b0;

  id_handle_allocator_top #(
    .CAPACITY (CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  iha_checker #(
    .CAPACITY (CAPACITY)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t make_op(input logic [1:0] mode, input int start,
                                       input int slot_id, input logic [31:0] value);
    in_item_t op;
    op.mode     = mode;
    op.start_id = ID_W'(start);
    op.id       = ID_W'(slot_id);
    op.value    = value;
    return op;
  endfunction

  // Slot ids lean toward a low window so scans stay short and removes land
  // on live entries; the top window fills up and exercises the full case
  function automatic int pick_slot(input int low_span, input int low_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < low_pct) return $urandom_range(0, low_span - 1);
    if (r < low_pct + (100 - low_pct) / 2) return $urandom_range(CAPACITY - 32, CAPACITY - 1);
    if (r < 95) return $urandom_range(0, CAPACITY - 1);
    return $urandom_range(CAPACITY, 65535);
  endfunction

  function automatic in_item_t random_op();
    in_item_t op;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 35)      op.mode = OP_ALLOC;
    else if (r < 65) op.mode = OP_FIND;
    else if (r < 95) op.mode = OP_REMOVE;
    else             op.mode = OP_UNUSED;
    op.start_id = ID_W'(pick_slot(64, 50));
    op.id       = ID_W'((op.mode == OP_REMOVE) ? pick_slot(128, 75) : pick_slot(128, 70));
    r = $urandom_range(0, 99);
    if (r < 10)      op.value = '0;
    else if (r < 15) op.value = '1;
    else             op.value = $urandom;
    return op;
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic drive_op(input in_item_t op);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= op;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Receiver: phases of always-ready, coin-flip and sparse ready, plus one
  // long hold-off on request
  initial begin : result_sink
    int   phase_left;
    int   style;
    logic hold_done;
    phase_left = 0;
    style      = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (phase_left == 0) begin
          style      = $urandom_range(0, 2);
          phase_left = $urandom_range(20, 300);
        end
        phase_left--;
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int burst_left;
    int gap;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, full and out-of-range cases
    drive_op(make_op(OP_FIND,   0,          0,          32'h0));
    drive_op(make_op(OP_ALLOC,  0,          65535,      32'hFFFF_FFFF));
    drive_op(make_op(OP_FIND,   65535,      0,          32'h0));
    drive_op(make_op(OP_ALLOC,  0,          0,          32'h0));          // zero value stays free
    drive_op(make_op(OP_ALLOC,  0,          0,          32'h1234_5678));  // reuses that slot
    drive_op(make_op(OP_FIND,   0,          1,          32'h0));
    drive_op(make_op(OP_ALLOC,  CAPACITY-1, 0,          32'h1));          // last slot
    drive_op(make_op(OP_ALLOC,  CAPACITY-1, 0,          32'h2));          // full above start
    drive_op(make_op(OP_ALLOC,  CAPACITY,   0,          32'h3));          // start past table
    drive_op(make_op(OP_ALLOC,  65535,      65535,      32'hFFFF_FFFF));
    drive_op(make_op(OP_FIND,   0,          CAPACITY-1, 32'h0));
    drive_op(make_op(OP_FIND,   0,          CAPACITY,   32'h0));          // find out of range
    drive_op(make_op(OP_FIND,   0,          65535,      32'hFFFF_FFFF));
    drive_op(make_op(OP_REMOVE, 0,          CAPACITY,   32'h0));          // remove out of range
    drive_op(make_op(OP_REMOVE, 65535,      65535,      32'hFFFF_FFFF));
    drive_op(make_op(OP_REMOVE, 0,          5,          32'h0));          // remove of free slot
    drive_op(make_op(OP_REMOVE, 0,          0,          32'h0));
    drive_op(make_op(OP_FIND,   0,          0,          32'h0));
    drive_op(make_op(OP_UNUSED, 65535,      65535,      32'hFFFF_FFFF));  // ignored mode
    drive_op(make_op(OP_UNUSED, 0,          0,          32'h0));
    drive_op(make_op(OP_REMOVE, 0,          CAPACITY-1, 32'h0));
    drive_op(make_op(OP_ALLOC,  CAPACITY-2, 0,          32'hA5A5_5A5A));
    drive_op(make_op(OP_FIND,   0,          CAPACITY-2, 32'h0));
    wait_drained();

    // Random part, starting under a long receiver hold-off
    hold_req   = 1'b1;
    sent       = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == RANDOM_ITEMS / 2) wait_drained();
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                 : $urandom_range(1, 40);
        gap = $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      drive_op(random_op());
      burst_left--;
      sent++;
    end

    wait_drained();
    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
